// ----- hw/rtl/bkt_avg_pkg.sv -----
// Shared types and constants for the bucket average downsampler.
`timescale 1ns / 1ps
package bkt_avg_pkg;

	localparam int NUM_VALUES   = 8;
	localparam int CHANNELS_DEF = 8;
	localparam int SAMPLE_W     = 16;
	localparam int TS_W         = 32;
	localparam int COUNT_W      = 17;
	localparam int SUM_W        = 33;
	localparam int SCALE_W      = 13;
	localparam int DEN_W        = SCALE_W + COUNT_W;
	localparam int DIV_W        = 32;
	localparam int ITER_W       = 6;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int DATA_W       = TS_W + NUM_VALUES * SAMPLE_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
	localparam logic [15:0]        DIVISOR_RST = 16'd60;
	localparam logic [15:0]        WATTS_RST   = 16'd10;
	// floor(w / 10) = (w * 52429) >> 19 for any 16-bit w
	localparam logic [15:0]        RECIP_10    = 16'd52429;
	localparam int                 RECIP_SHIFT = 19;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_DIVISOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WATTS        = 1'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [NUM_VALUES-1:0][SAMPLE_W-1:0] sample_vec_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  low;
		logic [ITER_W-1:0] iters;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [TS_W-1:0]   bucket;
		sample_vec_t       avg;
		logic              last;
	} result_t;

endpackage

// ----- hw/rtl/bkt_avg_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bkt_avg_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bkt_avg_pkg::div_req_t req,
	output bkt_avg_pkg::div_rsp_t rsp
);

	logic [bkt_avg_pkg::DIV_W-1:0]  rem_q;
	logic [bkt_avg_pkg::DIV_W-1:0]  low_q;
	logic [bkt_avg_pkg::DIV_W-1:0]  quo_q;
	logic [bkt_avg_pkg::DIV_W-1:0]  div_q;
	logic [bkt_avg_pkg::ITER_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [bkt_avg_pkg::DIV_W:0]   shifted;
	logic [bkt_avg_pkg::DIV_W:0]   diff;
	logic                          qbit;
	logic [bkt_avg_pkg::DIV_W-1:0] rem_next;

	// remainder stays below the divisor, so one shifted-in bit fits in DIV_W+1
	always_comb begin
		shifted  = {rem_q, low_q[bkt_avg_pkg::DIV_W-1]};
		diff     = shifted - {1'b0, div_q};
		qbit     = (shifted >= {1'b0, div_q});
		rem_next = qbit ? diff[bkt_avg_pkg::DIV_W-1:0] : shifted[bkt_avg_pkg::DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bkt_avg_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			low_q <= req.low;
			quo_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			low_q <= {low_q[bkt_avg_pkg::DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[bkt_avg_pkg::DIV_W-2:0], qbit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ----- hw/rtl/bkt_avg_seq.sv -----
// Sequencer: bucket state, accumulation and scheduling of the shared divider.
`timescale 1ns / 1ps
module bkt_avg_seq #(
	parameter int CHANNELS = bkt_avg_pkg::CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bkt_avg_pkg::TS_W-1:0]     in_ts,
	input  bkt_avg_pkg::sample_vec_t         in_vals,
	input  logic                             in_eod,
	input  logic [15:0]                      time_divisor,
	input  logic [15:0]                      watts,
	input  logic                             out_free,
	output bkt_avg_pkg::result_t             res
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_TDIV  = 9'b000000010,
		ST_CHECK = 9'b000000100,
		ST_ACC   = 9'b000001000,
		ST_SCALE = 9'b000010000,
		ST_DEN   = 9'b000100000,
		ST_CHS   = 9'b001000000,
		ST_CHW   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic                                  valid_q;
	logic                                  eod_q;
	logic                                  last_q;
	logic [bkt_avg_pkg::TS_W-1:0]          open_q;
	logic [bkt_avg_pkg::TS_W-1:0]          bucket_q;
	logic [bkt_avg_pkg::COUNT_W-1:0]       count_q;
	logic [CH_W-1:0]                       ch_q;
	logic [bkt_avg_pkg::SCALE_W-1:0]       scale_q;
	logic [bkt_avg_pkg::DEN_W-1:0]         den_q;
	bkt_avg_pkg::sample_vec_t              vals_q;
	logic signed [bkt_avg_pkg::SUM_W-1:0]  sum_q [CHANNELS];
	logic [bkt_avg_pkg::SAMPLE_W-1:0]      avg_q [CHANNELS];

	bkt_avg_pkg::div_req_t div_req;
	bkt_avg_pkg::div_rsp_t div_rsp;

	logic                                  accept;
	logic [15:0]                           eff_div;
	logic [31:0]                           scale_prod;
	logic [bkt_avg_pkg::SCALE_W-1:0]       scale_raw;
	logic [bkt_avg_pkg::COUNT_W-1:0]       eff_count;
	logic signed [bkt_avg_pkg::SUM_W-1:0]  cur_sum;
	logic                                  cur_neg;
	logic [bkt_avg_pkg::SUM_W-1:0]         neg_sum;
	logic [31:0]                           mag;
	logic [33:0]                           dvd;
	logic [bkt_avg_pkg::DEN_W:0]           dvs;
	logic                                  ovf;
	logic [15:0]                           sat_val;
	logic [15:0]                           quot16;
	logic [15:0]                           div_val;

	bkt_avg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign eff_div  = (time_divisor == 16'd0) ? 16'd1 : time_divisor;

	assign scale_prod = 32'(watts) * 32'(bkt_avg_pkg::RECIP_10);
	assign scale_raw  = scale_prod[bkt_avg_pkg::RECIP_SHIFT +: bkt_avg_pkg::SCALE_W];
	assign eff_count  = (count_q == '0) ? bkt_avg_pkg::COUNT_W'(1) : count_q;

	// rounded quotient: (2|s| + den) / (2 den)
	always_comb begin
		cur_sum = sum_q[ch_q];
		cur_neg = cur_sum[bkt_avg_pkg::SUM_W-1];
		neg_sum = -cur_sum;
		mag     = cur_neg ? neg_sum[31:0] : cur_sum[31:0];
		dvd     = {1'b0, mag, 1'b0} + 34'(den_q);
		dvs     = {den_q, 1'b0};
		ovf     = (32'(dvd[33:16]) >= 32'(dvs));
		sat_val = cur_neg ? 16'h8000 : 16'h7fff;
		quot16  = div_rsp.quot[15:0];
		if (cur_neg) begin
			div_val = (quot16 > 16'd32768) ? 16'h8000 : -quot16;
		end else begin
			div_val = (quot16 > 16'd32767) ? 16'h7fff : quot16;
		end
	end

	always_comb begin
		div_req = '0;
		if (accept) begin
			div_req.start   = 1'b1;
			div_req.low     = in_ts;
			div_req.iters   = bkt_avg_pkg::ITER_W'(32);
			div_req.divisor = 32'(eff_div);
		end else if (state_q == ST_CHS && !ovf) begin
			div_req.start    = 1'b1;
			div_req.rem_init = 32'(dvd[33:16]);
			div_req.low      = {dvd[15:0], 16'd0};
			div_req.iters    = bkt_avg_pkg::ITER_W'(16);
			div_req.divisor  = 32'(dvs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			count_q <= '0;
			ch_q    <= '0;
			last_q  <= 1'b0;
			eod_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						eod_q   <= in_eod;
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (div_rsp.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (valid_q && bucket_q != open_q) begin
						last_q  <= 1'b0;
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!valid_q) begin
						valid_q <= 1'b1;
						count_q <= bkt_avg_pkg::COUNT_W'(1);
					end else if (count_q != bkt_avg_pkg::COUNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
					if (eod_q) begin
						last_q  <= 1'b1;
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCALE: begin
					ch_q    <= '0;
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					state_q <= ST_CHS;
				end
				ST_CHS: begin
					if (!ovf) begin
						state_q <= ST_CHW;
					end else if (ch_q == CH_LAST) begin
						state_q <= ST_OUT;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_CHW: begin
					if (div_rsp.done) begin
						if (ch_q == CH_LAST) begin
							state_q <= ST_OUT;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_CHS;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						valid_q <= 1'b0;
						if (last_q) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ACC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vals_q <= in_vals;
		end
		if (state_q == ST_TDIV && div_rsp.done) begin
			bucket_q <= div_rsp.quot;
		end
		if (state_q == ST_ACC) begin
			// a fresh bucket starts from this sample alone
			if (!valid_q) begin
				open_q <= bucket_q;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				if (!valid_q) begin
					sum_q[c] <= bkt_avg_pkg::SUM_W'(signed'(vals_q[c]));
				end else if (count_q != bkt_avg_pkg::COUNT_MAX) begin
					sum_q[c] <= sum_q[c] + bkt_avg_pkg::SUM_W'(signed'(vals_q[c]));
				end
			end
		end
		if (state_q == ST_SCALE) begin
			scale_q <= (scale_raw == '0) ? bkt_avg_pkg::SCALE_W'(1) : scale_raw;
		end
		if (state_q == ST_DEN) begin
			den_q <= bkt_avg_pkg::DEN_W'(scale_q) * bkt_avg_pkg::DEN_W'(eff_count);
		end
		if (state_q == ST_CHS && ovf) begin
			avg_q[ch_q] <= sat_val;
		end
		if (state_q == ST_CHW && div_rsp.done) begin
			avg_q[ch_q] <= div_val;
		end
	end

	always_comb begin
		res.valid  = (state_q == ST_OUT) && out_free;
		res.bucket = open_q;
		res.last   = last_q;
		res.avg    = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			res.avg[c] = avg_q[c];
		end
	end

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_div_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_TDIV || state_q == ST_CHW))
		else $error("divider result with no waiting state");

	a_emit_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |-> (valid_q && count_q != '0))
		else $error("emitting a bucket that is not open");

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> !valid_q)
		else $error("bucket still open after its result");

endmodule

// ----- hw/rtl/bucket_average_downsampler_top.sv -----
// Top level: stream ports, configuration registers and output register.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata, s_tlast (end_of_data)
//  m_*       out  m_tvalid / m_tready       m_tdata, m_tlast (final_bucket)
//  cfg_*     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An input word runs a 32-bit bucket division on the shared divider, then
// compare and accumulate. Each result passes the scale and denominator
// states, then a 16-bit rounded division per channel, skipped on saturation.
// Reset leaves no open bucket and the registers at divisor 60, watts 10.
// The next input word is taken while a result waits in the output register;
// a stalled output holds the sequencer only when a second result is ready.
`timescale 1ns / 1ps
module bucket_average_downsampler_top #(
	parameter int CHANNELS = bkt_avg_pkg::CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// timestamp[31:0], value_0..value_7 16 bits each from bit 32 up
	input  logic [bkt_avg_pkg::DATA_W-1:0]        s_tdata,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// bucket_index[31:0], avg_0..avg_7 16 bits each from bit 32 up
	output logic [bkt_avg_pkg::DATA_W-1:0]        m_tdata,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bkt_avg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bkt_avg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [15:0]                          divisor_q;
	logic [15:0]                          watts_q;
	logic                                 m_valid_q;
	logic [bkt_avg_pkg::DATA_W-1:0]       m_data_q;
	logic                                 m_last_q;
	logic                                 out_free;
	bkt_avg_pkg::sample_vec_t             in_vals;
	bkt_avg_pkg::result_t                 res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= bkt_avg_pkg::DIVISOR_RST;
			watts_q   <= bkt_avg_pkg::WATTS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bkt_avg_pkg::REG_TIME_DIVISOR: divisor_q <= cfg_data;
				bkt_avg_pkg::REG_WATTS:        watts_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_vals = s_tdata[bkt_avg_pkg::DATA_W-1:bkt_avg_pkg::TS_W];

	bkt_avg_seq #(
		.CHANNELS (CHANNELS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_ts        (s_tdata[bkt_avg_pkg::TS_W-1:0]),
		.in_vals      (in_vals),
		.in_eod       (s_tlast),
		.time_divisor (divisor_q),
		.watts        (watts_q),
		.out_free     (out_free),
		.res          (res)
	);

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_data_q <= {res.avg, res.bucket};
			m_last_q <= res.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule
